FILE: sv/sbsu_pkg.sv
// ----------------------------------------------------------------------------
// sbsu_pkg
// Shared types and constants of the self-organizing map search and update unit.
// ----------------------------------------------------------------------------
package sbsu_pkg;

    // item kinds carried in s_axis_tuser
    localparam logic [1:0] KIND_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE      = 2'd1;
    localparam logic [1:0] KIND_LOAD_KERNEL = 2'd2;
    localparam logic [1:0] KIND_READ_WEIGHT = 2'd3;

    // result kinds carried in m_axis_tuser
    localparam logic RES_BMU    = 1'b0;
    localparam logic RES_WEIGHT = 1'b1;

    // register select, taken from paddr[2]
    localparam logic REG_SIDE = 1'b0;
    localparam logic REG_DIMS = 1'b1;

    localparam int KERNEL_DEPTH = 8;
    localparam int KERNEL_AW    = 3;
    localparam int VAL_W        = 16;
    localparam int DIST_W       = 36;
    localparam int IN_TDATA_W   = 64;
    localparam int OUT_TDATA_W  = 64;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // input tdata layout
    localparam int IN_ROW_LSB  = 0;
    localparam int IN_COL_LSB  = 3;
    localparam int IN_ELEM_LSB = 6;
    localparam int IN_VAL_LSB  = 10;
    localparam int IN_RATE_LSB = 26;
    localparam int IN_KD_LSB   = 42;
    localparam int IN_KV_LSB   = 45;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_RDBACK  = 12'b0000_0000_0010,
        ST_SEARCH  = 12'b0000_0000_0100,
        ST_S_DRAIN = 12'b0000_0000_1000,
        ST_U_K1    = 12'b0000_0001_0000,
        ST_U_K2    = 12'b0000_0010_0000,
        ST_U_F1    = 12'b0000_0100_0000,
        ST_U_F2    = 12'b0000_1000_0000,
        ST_U_F3    = 12'b0001_0000_0000,
        ST_U_RUN   = 12'b0010_0000_0000,
        ST_U_DRAIN = 12'b0100_0000_0000,
        ST_REPORT  = 12'b1000_0000_0000
    } state_t;

endpackage

FILE: sv/som_bmu_search_and_update_unit.sv
// ----------------------------------------------------------------------------
// som_bmu_search_and_update_unit
// Self-organizing map training step: best matching unit search followed by a
// kernel-weighted pull of every neuron toward the sample, one shared multiplier.
// ----------------------------------------------------------------------------
// loads and plain sample elements are written as they are accepted; a weight readback
//   is read through the weight RAM's read register into the result register
// after the last sample element, the search streams one weight element per cycle over
//   every neuron in use, then the update runs each neuron through the kernel and factor
//   states on the shared multiplier before its elements, and the winner is reported
// the input is not ready while a search or update runs
// reset clears control state and sets the side and dims registers to 8 and 16; weight,
//   sample and kernel stores are undefined until written
module som_bmu_search_and_update_unit
    import sbsu_pkg::*;
#(
    parameter int MAP_SIDE    = 8,
    parameter int VECTOR_DIMS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // row, col, element, value, learning_rate, kernel_distance, kernel_value, pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [1:0]             s_axis_tuser,
    input  logic                   s_axis_tlast,
    // result channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // bmu_row, bmu_col, best_distance, weight_value, pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // result_kind
    output logic                   m_axis_tuser,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int RW     = $clog2(MAP_SIDE);
    localparam int EW     = (VECTOR_DIMS > 1) ? $clog2(VECTOR_DIMS) : 1;
    localparam int WAW    = 2 * RW + EW;
    localparam int WDEPTH = 2 ** WAW;
    localparam int SDEPTH = 2 ** EW;

    // ---------------- input fields
    logic [2:0]       in_row, in_col, in_kd;
    logic [3:0]       in_elem;
    logic [VAL_W-1:0] in_val, in_rate, in_kv;
    logic [31:0]      in_row_ext, in_col_ext, in_elem_ext;
    logic [RW-1:0]    in_row_idx, in_col_idx;
    logic [EW-1:0]    in_elem_idx;
    logic             in_inside, in_elem_ok;

    assign in_row  = s_axis_tdata[IN_ROW_LSB +: 3];
    assign in_col  = s_axis_tdata[IN_COL_LSB +: 3];
    assign in_elem = s_axis_tdata[IN_ELEM_LSB +: 4];
    assign in_val  = s_axis_tdata[IN_VAL_LSB +: VAL_W];
    assign in_rate = s_axis_tdata[IN_RATE_LSB +: VAL_W];
    assign in_kd   = s_axis_tdata[IN_KD_LSB +: 3];
    assign in_kv   = s_axis_tdata[IN_KV_LSB +: VAL_W];

    assign in_row_ext  = 32'(in_row);
    assign in_col_ext  = 32'(in_col);
    assign in_elem_ext = 32'(in_elem);
    assign in_row_idx  = in_row_ext[RW-1:0];
    assign in_col_idx  = in_col_ext[RW-1:0];
    assign in_elem_idx = in_elem_ext[EW-1:0];
    assign in_elem_ok  = in_elem_ext < VECTOR_DIMS;
    assign in_inside   = (in_row_ext < MAP_SIDE) && (in_col_ext < MAP_SIDE) && in_elem_ok;

    // ---------------- registers
    state_t            state_reg;
    logic [3:0]        side_reg;
    logic [4:0]        dims_reg;
    logic              m_valid_reg;
    logic              m_kind_reg;
    logic [2:0]        m_row_reg, m_col_reg;
    logic [DIST_W-1:0] m_dist_reg;
    logic [VAL_W-1:0]  m_weight_reg;

    logic [RW-1:0]     r_cnt_reg, c_cnt_reg;
    logic [EW-1:0]     e_cnt_reg;
    logic [VAL_W-1:0]  rate_reg, step_reg, kr_reg;
    logic              kz1_reg, kz2_reg, rb_inside_reg;
    logic [DIST_W-1:0] acc_reg, best_reg;
    logic [RW-1:0]     best_r_reg, best_c_reg;

    logic              p1_valid_reg, p1_upd_reg, p1_end_reg;
    logic [RW-1:0]     p1_row_reg, p1_col_reg;
    logic [EW-1:0]     p1_elem_reg;
    logic              p2_valid_reg, p2_upd_reg, p2_end_reg;
    logic [RW-1:0]     p2_row_reg, p2_col_reg;
    logic [EW-1:0]     p2_elem_reg;
    logic [VAL_W-1:0]  p2_w_reg;
    logic signed [35:0] prod_reg;

    // ---------------- configuration
    logic cfg_write;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_DIMS) ? 32'(dims_reg) : 32'(side_reg);

    // effective map side and vector length, as last indices
    logic [31:0]   side_clamped, dims_clamped, side_m1, dims_m1;
    logic [RW-1:0] side_last;
    logic [EW-1:0] dims_last;

    always_comb begin
        if (side_reg == 4'd0) begin
            side_clamped = 32'd1;
        end else if (32'(side_reg) > MAP_SIDE) begin
            side_clamped = 32'(MAP_SIDE);
        end else begin
            side_clamped = 32'(side_reg);
        end
        if (dims_reg == 5'd0) begin
            dims_clamped = 32'd1;
        end else if (32'(dims_reg) > VECTOR_DIMS) begin
            dims_clamped = 32'(VECTOR_DIMS);
        end else begin
            dims_clamped = 32'(dims_reg);
        end
        side_m1 = side_clamped - 32'd1;
        dims_m1 = dims_clamped - 32'd1;
    end

    assign side_last = side_m1[RW-1:0];
    assign dims_last = dims_m1[EW-1:0];

    // ---------------- handshake
    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---------------- sequencing helpers
    logic issue, elem_last, neuron_last;
    assign issue       = (state_reg == ST_SEARCH) || (state_reg == ST_U_RUN);
    assign elem_last   = e_cnt_reg == dims_last;
    assign neuron_last = (r_cnt_reg == side_last) && (c_cnt_reg == side_last);

    // grid offsets to the winner
    logic [RW-1:0]        dr, dc;
    logic [31:0]          dr_ext, dc_ext;
    logic [KERNEL_AW-1:0] k_raddr;
    logic                 dr_far, dc_far;

    assign dr      = (r_cnt_reg > best_r_reg) ? r_cnt_reg - best_r_reg : best_r_reg - r_cnt_reg;
    assign dc      = (c_cnt_reg > best_c_reg) ? c_cnt_reg - best_c_reg : best_c_reg - c_cnt_reg;
    assign dr_ext  = 32'(dr);
    assign dc_ext  = 32'(dc);
    assign dr_far  = dr_ext >= KERNEL_DEPTH;
    assign dc_far  = dc_ext >= KERNEL_DEPTH;
    assign k_raddr = (state_reg == ST_U_K1) ? dr_ext[KERNEL_AW-1:0] : dc_ext[KERNEL_AW-1:0];

    // ---------------- memories
    logic             w_we, s_we, k_we;
    logic [WAW-1:0]   w_waddr, w_raddr;
    logic [VAL_W-1:0] w_wdata, w_rdata, s_rdata, k_rdata;
    logic [VAL_W-1:0] nw;

    always_comb begin
        if (p2_valid_reg && p2_upd_reg) begin
            w_we    = 1'b1;
            w_waddr = {p2_row_reg, p2_col_reg, p2_elem_reg};
            w_wdata = nw;
        end else begin
            w_we    = accept && (s_axis_tuser == KIND_LOAD_WEIGHT) && in_inside;
            w_waddr = {in_row_idx, in_col_idx, in_elem_idx};
            w_wdata = in_val;
        end
    end

    assign w_raddr = (state_reg == ST_IDLE) ? {in_row_idx, in_col_idx, in_elem_idx}
                                            : {r_cnt_reg, c_cnt_reg, e_cnt_reg};
    assign s_we    = accept && (s_axis_tuser == KIND_SAMPLE) && in_elem_ok;
    assign k_we    = accept && (s_axis_tuser == KIND_LOAD_KERNEL);

    sbsu_ram #(.WIDTH(VAL_W), .DEPTH(WDEPTH)) u_weight_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    sbsu_ram #(.WIDTH(VAL_W), .DEPTH(SDEPTH)) u_sample_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (in_elem_idx),
        .wdata (in_val),
        .raddr (e_cnt_reg),
        .rdata (s_rdata)
    );

    sbsu_ram #(.WIDTH(VAL_W), .DEPTH(KERNEL_DEPTH)) u_kernel_ram (
        .aclk  (aclk),
        .we    (k_we),
        .waddr (in_kd),
        .wdata (in_kv),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    // ---------------- shared multiplier
    logic signed [16:0] diff;
    logic signed [17:0] mul_a, mul_b;
    logic [VAL_W-1:0]   kc;

    assign diff = {s_rdata[VAL_W-1], s_rdata} - {w_rdata[VAL_W-1], w_rdata};
    assign kc   = kz2_reg ? '0 : k_rdata;

    always_comb begin
        if (p1_valid_reg) begin
            mul_b = {diff[16], diff};
            mul_a = p1_upd_reg ? {2'b00, step_reg} : {diff[16], diff};
        end else if (state_reg == ST_U_F2) begin
            mul_a = {2'b00, prod_reg[31:16]};
            mul_b = {2'b00, rate_reg};
        end else begin
            mul_a = {2'b00, kr_reg};
            mul_b = {2'b00, kc};
        end
    end

    // ---------------- stage 2 arithmetic
    logic [36:0]        dist_sum;
    logic [DIST_W-1:0]  dist_sat;
    logic signed [19:0] upd;
    logic signed [20:0] nw_wide;
    logic               first_neuron;

    assign dist_sum     = {1'b0, acc_reg} + {5'b0, prod_reg[31:0]};
    assign dist_sat     = dist_sum[36] ? DIST_MAX : dist_sum[DIST_W-1:0];
    assign first_neuron = (p2_row_reg == '0) && (p2_col_reg == '0);

    // arithmetic shift gives the floor of the scaled update
    assign upd     = prod_reg[35:16];
    assign nw_wide = {{5{p2_w_reg[VAL_W-1]}}, p2_w_reg} + {upd[19], upd};

    always_comb begin
        if (nw_wide > 21'sd32767) begin
            nw = 16'h7FFF;
        end else if (nw_wide < -21'sd32768) begin
            nw = 16'h8000;
        end else begin
            nw = nw_wide[VAL_W-1:0];
        end
    end

    // ---------------- control registers
    logic out_free;
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            side_reg     <= 4'd8;
            dims_reg     <= 5'd16;
            m_valid_reg  <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                if (paddr[2] == REG_SIDE) begin
                    side_reg <= pwdata[3:0];
                end else begin
                    dims_reg <= pwdata[4:0];
                end
            end
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_axis_tuser == KIND_READ_WEIGHT) begin
                            state_reg <= ST_RDBACK;
                        end else if (s_axis_tuser == KIND_SAMPLE && s_axis_tlast) begin
                            state_reg <= ST_SEARCH;
                        end
                    end
                end
                ST_RDBACK: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                ST_SEARCH: begin
                    if (elem_last && neuron_last) begin
                        state_reg <= ST_S_DRAIN;
                    end
                end
                ST_S_DRAIN: begin
                    if (!p1_valid_reg && !p2_valid_reg) begin
                        state_reg <= ST_U_K1;
                    end
                end
                ST_U_K1: state_reg <= ST_U_K2;
                ST_U_K2: state_reg <= ST_U_F1;
                ST_U_F1: state_reg <= ST_U_F2;
                ST_U_F2: state_reg <= ST_U_F3;
                ST_U_F3: state_reg <= ST_U_RUN;
                ST_U_RUN: begin
                    if (elem_last) begin
                        state_reg <= neuron_last ? ST_U_DRAIN : ST_U_K1;
                    end
                end
                ST_U_DRAIN: begin
                    if (!p1_valid_reg && !p2_valid_reg) begin
                        state_reg <= ST_REPORT;
                    end
                end
                ST_REPORT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------- datapath registers
    logic [31:0] best_r_ext, best_c_ext;
    assign best_r_ext = 32'(best_r_reg);
    assign best_c_ext = 32'(best_c_reg);

    always_ff @(posedge aclk) begin
        prod_reg    <= 36'(mul_a) * 36'(mul_b);

        p1_upd_reg  <= (state_reg == ST_U_RUN);
        p1_end_reg  <= elem_last;
        p1_row_reg  <= r_cnt_reg;
        p1_col_reg  <= c_cnt_reg;
        p1_elem_reg <= e_cnt_reg;
        p2_upd_reg  <= p1_upd_reg;
        p2_end_reg  <= p1_end_reg;
        p2_row_reg  <= p1_row_reg;
        p2_col_reg  <= p1_col_reg;
        p2_elem_reg <= p1_elem_reg;
        p2_w_reg    <= w_rdata;

        // distance accumulation and running minimum
        if (p2_valid_reg && !p2_upd_reg) begin
            if (p2_end_reg) begin
                acc_reg <= '0;
                if (first_neuron || dist_sat < best_reg) begin
                    best_reg   <= dist_sat;
                    best_r_reg <= p2_row_reg;
                    best_c_reg <= p2_col_reg;
                end
            end else begin
                acc_reg <= dist_sat;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                r_cnt_reg     <= '0;
                c_cnt_reg     <= '0;
                e_cnt_reg     <= '0;
                acc_reg       <= '0;
                rb_inside_reg <= in_inside;
                if (accept && s_axis_tuser == KIND_SAMPLE && s_axis_tlast) begin
                    rate_reg <= in_rate;
                end
            end
            ST_S_DRAIN: begin
                r_cnt_reg <= '0;
                c_cnt_reg <= '0;
                e_cnt_reg <= '0;
            end
            ST_U_K1: begin
                kz1_reg <= dr_far;
            end
            ST_U_K2: begin
                kr_reg  <= kz1_reg ? '0 : k_rdata;
                kz2_reg <= dc_far;
            end
            ST_U_F3: begin
                step_reg <= prod_reg[31:16];
            end
            default: begin
            end
        endcase

        // neuron and element walk shared by search and update
        if (issue) begin
            if (elem_last) begin
                e_cnt_reg <= '0;
                if (c_cnt_reg == side_last) begin
                    c_cnt_reg <= '0;
                    r_cnt_reg <= r_cnt_reg + 1'b1;
                end else begin
                    c_cnt_reg <= c_cnt_reg + 1'b1;
                end
            end else begin
                e_cnt_reg <= e_cnt_reg + 1'b1;
            end
        end

        // result register
        if (state_reg == ST_RDBACK) begin
            m_kind_reg   <= RES_WEIGHT;
            m_row_reg    <= '0;
            m_col_reg    <= '0;
            m_dist_reg   <= '0;
            m_weight_reg <= rb_inside_reg ? w_rdata : '0;
        end else if (state_reg == ST_REPORT && out_free) begin
            m_kind_reg   <= RES_BMU;
            m_row_reg    <= best_r_ext[2:0];
            m_col_reg    <= best_c_ext[2:0];
            m_dist_reg   <= best_reg;
            m_weight_reg <= '0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tdata  = {6'b0, m_weight_reg, m_dist_reg, m_col_reg, m_row_reg};

endmodule

FILE: sv/sbsu_ram.sv
// ----------------------------------------------------------------------------
// sbsu_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbsu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/som_bmu_search_and_update_unit_tb.sv
// ----------------------------------------------------------------------------
// som_bmu_search_and_update_unit_tb
// Self-checking bench for one online training step of the map: loads weights
// and kernel entries, streams samples at several map sizes, and compares every
// winner report and weight readback against a cycle-free model of the step.
// ----------------------------------------------------------------------------
module som_bmu_search_and_update_unit_tb;
    import sbsu_pkg::*;

    localparam int SIDE_MAX      = 8;
    localparam int DIMS_MAX      = 16;
    localparam int WEIGHT_DEPTH  = SIDE_MAX * SIDE_MAX * DIMS_MAX;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PHASE_ITEMS   = 120;
    localparam int NUM_PHASES    = 10;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_PRINTED   = 30;

    typedef struct {
        logic [1:0]              kind;
        logic [2:0]              row;
        logic [2:0]              col;
        logic [3:0]              element;
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic [15:0]             rate;
        logic [KERNEL_AW-1:0]    kd;
        logic [15:0]             kv;
    } som_item_t;

    typedef struct {
        logic                    rkind;
        logic [2:0]              brow;
        logic [2:0]              bcol;
        logic [DIST_W-1:0]       distance;
        logic signed [VAL_W-1:0] wval;
    } som_result_t;

    // model of the map state; predicts reports and readbacks per transaction
    class som_scoreboard;
        logic signed [VAL_W-1:0] weights [WEIGHT_DEPTH];
        logic signed [VAL_W-1:0] sample [DIMS_MAX];
        logic [15:0]             kernel [KERNEL_DEPTH];
        logic [3:0]              side_reg;
        logic [4:0]              dims_reg;
        som_result_t             pending_outputs [$];
        int                      errors;
        int                      reports_seen;
        int                      readbacks_seen;

        function new();
            foreach (weights[i]) weights[i] = '0;
            foreach (sample[i]) sample[i] = '0;
            foreach (kernel[i]) kernel[i] = '0;
            side_reg = 4'd8;
            dims_reg = 5'd16;
            errors = 0;
            reports_seen = 0;
            readbacks_seen = 0;
        endfunction

        function int eff_side();
            if (side_reg == 0) return 1;
            if (side_reg > SIDE_MAX) return SIDE_MAX;
            return side_reg;
        endfunction

        function int eff_dims();
            if (dims_reg == 0) return 1;
            if (dims_reg > DIMS_MAX) return DIMS_MAX;
            return dims_reg;
        endfunction

        function void set_reg(logic sel, logic [31:0] v);
            if (sel == REG_SIDE) side_reg = v[3:0];
            else dims_reg = v[4:0];
        endfunction

        function int widx(int r, int c, int e);
            return (r * SIDE_MAX + c) * DIMS_MAX + e;
        endfunction

        function void train_step(input logic [15:0] rate, output som_result_t res);
            int     side, dims, br, bc, dr, dc, i;
            longint best, sq_sum, diff, fac, step, w, nw;
            bit     have;
            side = eff_side();
            dims = eff_dims();
            have = 0;
            best = 0;
            br = 0;
            bc = 0;
            for (int r = 0; r < side; r++) begin
                for (int c = 0; c < side; c++) begin
                    sq_sum = 0;
                    for (int e = 0; e < dims; e++) begin
                        diff = longint'(sample[e]) - longint'(weights[widx(r, c, e)]);
                        sq_sum += diff * diff;
                    end
                    if (sq_sum > longint'(DIST_MAX)) sq_sum = longint'(DIST_MAX);
                    // strict compare keeps the first neuron in row-major order on ties
                    if (!have || sq_sum < best) begin
                        have = 1;
                        best = sq_sum;
                        br = r;
                        bc = c;
                    end
                end
            end
            for (int r = 0; r < side; r++) begin
                dr = (r > br) ? r - br : br - r;
                for (int c = 0; c < side; c++) begin
                    dc = (c > bc) ? c - bc : bc - c;
                    fac = (longint'(kernel[dr]) * longint'(kernel[dc])) >> 16;
                    step = (fac * longint'(rate)) >> 16;
                    for (int e = 0; e < dims; e++) begin
                        i = widx(r, c, e);
                        w = longint'(weights[i]);
                        diff = longint'(sample[e]) - w;
                        // arithmetic shift floors toward minus infinity
                        nw = w + ((step * diff) >>> 16);
                        if (nw > 32767) nw = 32767;
                        if (nw < -32768) nw = -32768;
                        weights[i] = nw[VAL_W-1:0];
                    end
                end
            end
            res.rkind = RES_BMU;
            res.brow = br[2:0];
            res.bcol = bc[2:0];
            res.distance = best[DIST_W-1:0];
            res.wval = '0;
        endfunction

        function void take_item(som_item_t it);
            som_result_t res;
            case (it.kind)
                KIND_LOAD_WEIGHT: weights[widx(it.row, it.col, it.element)] = it.value;
                KIND_LOAD_KERNEL: kernel[it.kd] = it.kv;
                KIND_READ_WEIGHT: begin
                    res.rkind = RES_WEIGHT;
                    res.brow = '0;
                    res.bcol = '0;
                    res.distance = '0;
                    res.wval = weights[widx(it.row, it.col, it.element)];
                    pending_outputs.push_back(res);
                end
                default: begin
                    sample[it.element] = it.value;
                    if (it.last) begin
                        train_step(it.rate, res);
                        pending_outputs.push_back(res);
                    end
                end
            endcase
        endfunction

        function void flag(string field, longint want, longint got);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_result(logic kind, logic [OUT_TDATA_W-1:0] data);
            som_result_t want;
            som_result_t got;
            got.rkind = kind;
            got.brow = data[2:0];
            got.bcol = data[5:3];
            got.distance = data[41:6];
            got.wval = data[57:42];
            if (pending_outputs.size() == 0) begin
                errors++;
                if (errors <= MAX_PRINTED)
                    $display("%0t: result with nothing pending, expected none, actual kind %0d",
                             $time, kind);
                return;
            end
            want = pending_outputs.pop_front();
            if (want.rkind == RES_BMU) reports_seen++;
            else readbacks_seen++;
            if (got.rkind !== want.rkind) flag("result_kind", want.rkind, got.rkind);
            if (got.brow !== want.brow) flag("bmu_row", want.brow, got.brow);
            if (got.bcol !== want.bcol) flag("bmu_col", want.bcol, got.bcol);
            if (got.distance !== want.distance)
                flag("best_distance", want.distance, got.distance);
            if (got.wval !== want.wval) flag("weight_value", want.wval, got.wval);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    som_scoreboard board = new();

    bit weight_written [WEIGHT_DEPTH];
    bit sample_written [DIMS_MAX];
    int items_sent      = 0;
    int counted_items   = 0;
    bit count_items     = 0;
    int settings_done   = 0;
    int stall_request   = 0;
    bit sender_eager    = 0;
    bit receiver_eager  = 0;
    int cycle_count     = 0;

    som_bmu_search_and_update_unit #(
        .MAP_SIDE    (SIDE_MAX),
        .VECTOR_DIMS (DIMS_MAX)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     board.pending_outputs.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold on request
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (stall_request > 0) gap = stall_request;
            else gap = receiver_eager ? 0 : $urandom_range(0, 3);
            stall_request = 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            board.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 16'h7FFF;
        if (sel == 1) return 16'h8000;
        // narrow values make equal distances, and so ties, likely
        if (sel < 4) return 16'($urandom_range(0, 4)) - 16'd2;
        return 16'($urandom);
    endfunction

    function automatic som_item_t random_item(logic [1:0] kind);
        som_item_t it;
        it.kind = kind;
        it.row = 3'($urandom_range(0, 7));
        it.col = 3'($urandom_range(0, 7));
        it.element = 4'($urandom_range(0, 15));
        it.value = pick_value();
        it.last = 1'($urandom_range(0, 1));
        it.rate = 16'($urandom);
        it.kd = 3'($urandom_range(0, 7));
        it.kv = 16'($urandom);
        return it;
    endfunction

    // valid is left high so back-to-back transactions need no second assignment
    task automatic send_item(input som_item_t it);
        int gap;
        logic [IN_TDATA_W-1:0] d;
        gap = sender_eager ? 0 : $urandom_range(0, 3);
        d = '0;
        d[IN_ROW_LSB +: 3] = it.row;
        d[IN_COL_LSB +: 3] = it.col;
        d[IN_ELEM_LSB +: 4] = it.element;
        d[IN_VAL_LSB +: VAL_W] = it.value;
        d[IN_RATE_LSB +: 16] = it.rate;
        d[IN_KD_LSB +: KERNEL_AW] = it.kd;
        d[IN_KV_LSB +: 16] = it.kv;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= it.kind;
        s_axis_tlast <= it.last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.take_item(it);
        if (it.kind == KIND_LOAD_WEIGHT)
            weight_written[board.widx(it.row, it.col, it.element)] = 1'b1;
        if (it.kind == KIND_SAMPLE) sample_written[it.element] = 1'b1;
        items_sent++;
        if (count_items) counted_items++;
    endtask

    task automatic wait_outputs_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_outputs.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input logic sel, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        board.set_reg(sel, v);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(input int side, input int dims);
        wait_outputs_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        apb_write(REG_SIDE, ($urandom & 32'hFFFF_FFF0) | 32'(side));
        apb_write(REG_DIMS, ($urandom & 32'hFFFF_FFE0) | 32'(dims));
        settings_done++;
    endtask

    // a search reads every weight in use, so load whatever is still unwritten
    task automatic ensure_weights();
        som_item_t it;
        bit        saved;
        saved = count_items;
        count_items = 0;
        for (int r = 0; r < board.eff_side(); r++) begin
            for (int c = 0; c < board.eff_side(); c++) begin
                for (int e = 0; e < board.eff_dims(); e++) begin
                    if (!weight_written[board.widx(r, c, e)]) begin
                        it = random_item(KIND_LOAD_WEIGHT);
                        it.row = r[2:0];
                        it.col = c[2:0];
                        it.element = e[3:0];
                        send_item(it);
                    end
                end
            end
        end
        count_items = saved;
    endtask

    task automatic send_sample_run(input bit in_order);
        som_item_t it;
        int        dims, j, tmp;
        int        order [DIMS_MAX];
        ensure_weights();
        dims = board.eff_dims();
        for (int i = 0; i < dims; i++) order[i] = i;
        if (!in_order) begin
            for (int i = dims - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
        end
        for (int i = 0; i < dims; i++) begin
            it = random_item(KIND_SAMPLE);
            it.element = order[i][3:0];
            it.last = (i == dims - 1);
            send_item(it);
        end
    endtask

    task automatic send_readback();
        som_item_t it;
        int        idx;
        do idx = $urandom_range(0, WEIGHT_DEPTH - 1); while (!weight_written[idx]);
        it = random_item(KIND_READ_WEIGHT);
        it.row = idx[9:7];
        it.col = idx[6:4];
        it.element = idx[3:0];
        send_item(it);
    endtask

    task automatic send_directed(input logic [1:0] kind, input int row, input int col,
                                 input int element, input logic [VAL_W-1:0] value,
                                 input logic last, input logic [15:0] rate);
        som_item_t it;
        it = random_item(kind);
        it.row = row[2:0];
        it.col = col[2:0];
        it.element = element[3:0];
        it.value = value;
        it.last = last;
        it.rate = rate;
        send_item(it);
    endtask

    task automatic run_directed();
        som_item_t it;
        apply_setting(2, 2);
        for (int k = 0; k < KERNEL_DEPTH; k++) begin
            it = random_item(KIND_LOAD_KERNEL);
            it.kd = k[KERNEL_AW-1:0];
            if (k == 0) it.kv = 16'hFFFF;
            if (k == KERNEL_DEPTH - 1) it.kv = 16'h0000;
            send_item(it);
        end
        // four equal neurons: the winner must be the first one
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 2; c++)
                for (int e = 0; e < 2; e++)
                    send_directed(KIND_LOAD_WEIGHT, r, c, e, 16'h0000, 1'b0, 16'h0000);
        send_directed(KIND_SAMPLE, 0, 0, 0, 16'h7FFF, 1'b0, 16'h0000);
        send_directed(KIND_SAMPLE, 0, 0, 1, 16'h8000, 1'b1, 16'hFFFF);
        send_directed(KIND_READ_WEIGHT, 0, 0, 0, 16'h0000, 1'b0, 16'h0000);
        send_directed(KIND_READ_WEIGHT, 1, 1, 1, 16'h0000, 1'b0, 16'h0000);
        // zero rate leaves the map unchanged
        send_directed(KIND_SAMPLE, 0, 0, 0, 16'h0000, 1'b0, 16'h0000);
        send_directed(KIND_SAMPLE, 0, 0, 1, 16'h0000, 1'b1, 16'h0000);
        send_directed(KIND_LOAD_WEIGHT, 7, 7, 15, 16'h8000, 1'b1, 16'hFFFF);
        send_directed(KIND_READ_WEIGHT, 7, 7, 15, 16'h0000, 1'b1, 16'hFFFF);
    endtask

    task automatic run_phase(input int count);
        som_item_t it;
        int        pick, dims, start;
        bit        ready_for_last;
        start = counted_items;
        while (counted_items - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_sample_run(pick < 32);
            end else if (pick < 50) begin
                it = random_item(KIND_SAMPLE);
                it.last = 1'b0;
                send_item(it);
            end else if (pick < 58) begin
                // last on an arbitrary element, only once the whole buffer holds data
                dims = board.eff_dims();
                it = random_item(KIND_SAMPLE);
                ready_for_last = 1'b1;
                for (int e = 0; e < dims; e++)
                    if (!sample_written[e] && e != it.element) ready_for_last = 1'b0;
                it.last = ready_for_last;
                if (ready_for_last) ensure_weights();
                send_item(it);
            end else if (pick < 73) begin
                send_item(random_item(KIND_LOAD_WEIGHT));
            end else if (pick < 93) begin
                send_readback();
            end else begin
                send_item(random_item(KIND_LOAD_KERNEL));
            end
        end
    endtask

    initial begin
        int side_list [NUM_PHASES] = '{8, 1, 0, 15, 3, 5, 8, 2, 4, 6};
        int dims_list [NUM_PHASES] = '{16, 1, 0, 31, 7, 16, 1, 9, 4, 12};
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= KIND_LOAD_WEIGHT;
        s_axis_tlast <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        count_items = 1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_setting(side_list[p], dims_list[p]);
            sender_eager = ($urandom_range(0, 3) == 0);
            receiver_eager = ($urandom_range(0, 3) == 0);
            if (p == 2) begin
                // hold the result side while readbacks keep coming, so the input stalls
                stall_request = LONG_HOLD;
                for (int i = 0; i < 24; i++) send_readback();
            end
            run_phase(PHASE_ITEMS / 2);
            if (p == 6) wait_outputs_drained();
            run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
        end

        wait_outputs_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.pending_outputs.size() != 0) board.errors++;

        $display("covered %0d input transactions under %0d register settings", items_sent,
                 settings_done);
        $display("checked %0d winner reports and %0d weight readbacks, %0d mismatches",
                 board.reports_seen, board.readbacks_seen, board.errors);
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: som_bmu_search_and_update_unit.f
sv/sbsu_pkg.sv
sv/sbsu_ram.sv
sv/som_bmu_search_and_update_unit.sv
tb/som_bmu_search_and_update_unit_tb.sv
